@@ hdl/pidc_pkg.sv @@
// Shared types, codes and microcode program of the PID pulse controller.
// Used by pidc_sequencer, pidc_datapath and pid_pwm_controller; no dependencies.
package pidc_pkg;

  // Step counter of the microcode sequencer
  localparam int unsigned STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_FETCH = 4'd0;
  localparam step_t STEP_FIRST = 4'd1;
  localparam step_t STEP_LAST  = 4'd8;

  // Operation codes carried on the input beat
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam int unsigned REG_W = 3;
  localparam logic [REG_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [REG_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [REG_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [REG_W-1:0] REG_TICK_PERIOD = 3'd3;
  localparam logic [REG_W-1:0] REG_TICK_RATE   = 3'd4;
  localparam logic [REG_W-1:0] REG_UPPER_LIMIT = 3'd5;
  localparam logic [REG_W-1:0] REG_LOWER_LIMIT = 3'd6;

  // Centre pulse width in microseconds
  localparam logic [12:0] CENTRE_US = 13'd1500;

  // Multiplier operand selection
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t MUL_NONE       = 3'd0;
  localparam mul_sel_t MUL_ERR_PERIOD = 3'd1;
  localparam mul_sel_t MUL_DIFF_RATE  = 3'd2;
  localparam mul_sel_t MUL_P          = 3'd3;
  localparam mul_sel_t MUL_I_LO       = 3'd4;
  localparam mul_sel_t MUL_I_HI       = 3'd5;
  localparam mul_sel_t MUL_D          = 3'd6;

  // Use of the product registered in the previous step
  typedef logic [2:0] act_t;
  localparam act_t ACT_NONE  = 3'd0;
  localparam act_t ACT_SUM   = 3'd1;
  localparam act_t ACT_DERIV = 3'd2;
  localparam act_t ACT_P     = 3'd3;
  localparam act_t ACT_I_LO  = 3'd4;
  localparam act_t ACT_I     = 3'd5;
  localparam act_t ACT_D     = 3'd6;
  localparam act_t ACT_OUT   = 3'd7;

  // Sequencing of the step counter
  typedef logic [1:0] jmp_t;
  localparam jmp_t JMP_NEXT     = 2'd0;
  localparam jmp_t JMP_DISPATCH = 2'd1;
  localparam jmp_t JMP_FINISH   = 2'd2;

  typedef struct packed {
    mul_sel_t mul_sel;
    act_t     act;
    jmp_t     jmp;
  } uword_t;

  // Control handed from the sequencer to the datapath
  typedef struct packed {
    uword_t word;
    logic   commit;
  } seq_ctrl_t;

  typedef struct packed {
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [15:0] tick_period;
    logic [9:0]  tick_rate;
    logic [11:0] upper_limit;
    logic [11:0] lower_limit;
  } cfg_t;

  // Result beat, first member in the highest bits: p_part lands at bit 0
  typedef struct packed {
    logic [11:0] pulse_width;
    logic [12:0] offset_drive;
    logic [31:0] d_part;
    logic [31:0] i_part;
    logic [31:0] p_part;
  } res_t;

  // Microcode program: multiply in step n, consume the product in step n+1
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      4'd0:    w = '{mul_sel: MUL_NONE,       act: ACT_NONE,  jmp: JMP_DISPATCH};
      4'd1:    w = '{mul_sel: MUL_ERR_PERIOD, act: ACT_NONE,  jmp: JMP_NEXT};
      4'd2:    w = '{mul_sel: MUL_DIFF_RATE,  act: ACT_SUM,   jmp: JMP_NEXT};
      4'd3:    w = '{mul_sel: MUL_P,          act: ACT_DERIV, jmp: JMP_NEXT};
      4'd4:    w = '{mul_sel: MUL_I_LO,       act: ACT_P,     jmp: JMP_NEXT};
      4'd5:    w = '{mul_sel: MUL_I_HI,       act: ACT_I_LO,  jmp: JMP_NEXT};
      4'd6:    w = '{mul_sel: MUL_D,          act: ACT_I,     jmp: JMP_NEXT};
      4'd7:    w = '{mul_sel: MUL_NONE,       act: ACT_D,     jmp: JMP_NEXT};
      4'd8:    w = '{mul_sel: MUL_NONE,       act: ACT_OUT,   jmp: JMP_FINISH};
      default: w = '{mul_sel: MUL_NONE,       act: ACT_NONE,  jmp: JMP_DISPATCH};
    endcase
    return w;
  endfunction

  // Saturate a signed value to the 32 bit range
  function automatic logic [31:0] sat32(input logic signed [47:0] x);
    logic [31:0] y;
    if (x > 48'sh0000_7FFF_FFFF) begin
      y = 32'h7FFF_FFFF;
    end else if (x < -48'sh0000_8000_0000) begin
      y = 32'h8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

endpackage

@@ hdl/pidc_sequencer.sv @@
// Microcode sequencer of the PID pulse controller: step counter and program lookup.
// Depends on pidc_pkg (program table, codes, control struct).
module pidc_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_op,
  input  logic                 out_free,
  output logic                 in_ready,
  output pidc_pkg::seq_ctrl_t  ctrl
);

  pidc_pkg::step_t  step_r;
  pidc_pkg::step_t  step_nxt;
  pidc_pkg::uword_t word;
  logic             commit;

  assign word = pidc_pkg::ucode(step_r);

  // Pick the next step from the jump field
  always_comb begin
    step_nxt = step_r;
    commit   = 1'b1;
    unique case (word.jmp)
      pidc_pkg::JMP_DISPATCH: begin
        if (in_valid && in_op == pidc_pkg::OP_TICK) begin
          step_nxt = pidc_pkg::STEP_FIRST;
        end
      end
      pidc_pkg::JMP_FINISH: begin
        commit = out_free;
        if (out_free) begin
          step_nxt = pidc_pkg::STEP_FETCH;
        end
      end
      pidc_pkg::JMP_NEXT: begin
        step_nxt = step_r + pidc_pkg::step_t'(1);
      end
      default: begin
        step_nxt = pidc_pkg::STEP_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pidc_pkg::STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign in_ready = (word.jmp == pidc_pkg::JMP_DISPATCH);
  assign ctrl     = '{word: word, commit: commit};

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= pidc_pkg::STEP_LAST)
    else $error("step counter left the program");

  a_tick_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ready && in_valid && in_op == pidc_pkg::OP_TICK) |=> step_r == pidc_pkg::STEP_FIRST)
    else $error("tick beat did not start the program");

  a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (word.jmp == pidc_pkg::JMP_FINISH && !out_free) |=> $stable(step_r))
    else $error("final step left while the result slot was full");

endmodule

@@ hdl/pidc_datapath.sv @@
// Datapath of the PID pulse controller: shared 17x28 multiplier, loop state and terms.
// Depends on pidc_pkg (codes, config and result structs, saturation helper).
module pidc_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pidc_pkg::cfg_t       cfg,
  input  pidc_pkg::seq_ctrl_t  ctrl,
  input  logic                 in_fire,
  input  logic [1:0]           in_op,
  input  logic [15:0]          in_err,
  output pidc_pkg::res_t       res
);

  // Loop state
  logic signed [15:0] held_r;
  logic signed [15:0] prior_r;
  logic signed [47:0] sum_r;
  logic signed [47:0] sum_nxt;

  // Product and term registers
  logic signed [44:0] prod_r;
  logic signed [26:0] deriv_r;
  logic signed [20:0] ilo_r;
  logic [31:0]        p_r;
  logic [31:0]        i_r;
  logic [31:0]        d_r;

  logic signed [16:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [44:0] prod_nxt;
  logic signed [48:0] sum_wide;
  logic signed [44:0] rnd8;
  logic signed [44:0] rnd24;
  logic signed [45:0] i_full;
  logic signed [34:0] total;
  logic [11:0]        pulse;
  logic               act_en;

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.word.mul_sel)
      pidc_pkg::MUL_ERR_PERIOD: begin
        mul_a = {held_r[15], held_r};
        mul_b = {12'd0, cfg.tick_period};
      end
      pidc_pkg::MUL_DIFF_RATE: begin
        mul_a = {prior_r[15], prior_r} - {held_r[15], held_r};
        mul_b = {18'd0, cfg.tick_rate};
      end
      pidc_pkg::MUL_P: begin
        mul_a = {cfg.gain_p[15], cfg.gain_p};
        mul_b = {{12{held_r[15]}}, held_r};
      end
      pidc_pkg::MUL_I_LO: begin
        mul_a = {cfg.gain_i[15], cfg.gain_i};
        mul_b = {4'd0, sum_r[23:0]};
      end
      pidc_pkg::MUL_I_HI: begin
        mul_a = {cfg.gain_i[15], cfg.gain_i};
        mul_b = {{4{sum_r[47]}}, sum_r[47:24]};
      end
      pidc_pkg::MUL_D: begin
        mul_a = {cfg.gain_d[15], cfg.gain_d};
        mul_b = {deriv_r[26], deriv_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // Integral update with saturation to 48 bits
  assign sum_wide = 49'(sum_r) + 49'(prod_r);
  always_comb begin
    if (sum_wide[48] != sum_wide[47]) begin
      sum_nxt = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      sum_nxt = sum_wide[47:0];
    end
  end

  // Round to nearest, ties up: add half then shift arithmetically
  assign rnd8   = (prod_r + 45'sd128) >>> 8;
  assign rnd24  = (prod_r + 45'sd8388608) >>> 24;
  assign i_full = 46'(prod_r) + 46'(ilo_r);

  // Pulse sum and clamp, upper limit first
  assign total = 35'sd1500 + 35'($signed(p_r)) + 35'($signed(i_r)) + 35'($signed(d_r));
  always_comb begin
    if (total > $signed({23'd0, cfg.upper_limit})) begin
      pulse = cfg.upper_limit;
    end else if (total < $signed({23'd0, cfg.lower_limit})) begin
      pulse = cfg.lower_limit;
    end else begin
      pulse = total[11:0];
    end
  end

  assign act_en = ctrl.commit;

  // Loop state: input beats and tick updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      prior_r <= '0;
      sum_r   <= '0;
    end else begin
      if (in_fire) begin
        case (in_op)
          pidc_pkg::OP_STORE: begin
            held_r <= in_err;
            sum_r  <= '0;
          end
          pidc_pkg::OP_CLEAR: begin
            sum_r <= '0;
          end
          default: begin
          end
        endcase
      end
      if (act_en && ctrl.word.act == pidc_pkg::ACT_SUM) begin
        sum_r <= sum_nxt;
      end
      if (act_en && ctrl.word.act == pidc_pkg::ACT_OUT) begin
        prior_r <= held_r;
      end
    end
  end

  // Product and term registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (act_en) begin
      case (ctrl.word.act)
        pidc_pkg::ACT_DERIV: deriv_r <= prod_r[26:0];
        pidc_pkg::ACT_P:     p_r     <= pidc_pkg::sat32(48'(rnd8));
        pidc_pkg::ACT_I_LO:  ilo_r   <= rnd24[20:0];
        pidc_pkg::ACT_I:     i_r     <= pidc_pkg::sat32(48'(i_full));
        pidc_pkg::ACT_D:     d_r     <= pidc_pkg::sat32(48'(rnd8));
        default: begin
        end
      endcase
    end
  end

  assign res.p_part       = p_r;
  assign res.i_part       = i_r;
  assign res.d_part       = d_r;
  assign res.pulse_width  = pulse;
  assign res.offset_drive = {1'b0, pulse} - pidc_pkg::CENTRE_US;

endmodule

@@ hdl/pid_pwm_controller.sv @@
// Top level of the PID pulse controller: config registers, stream ports, result register.
// Depends on pidc_pkg, pidc_sequencer and pidc_datapath.

// A store beat (tuser 1) latches tdata as the new error and clears the integral, a clear
// beat (tuser 2) clears the integral; both give no result, as does tuser 3. A tick beat
// (tuser 0) runs a microcode program of one dispatch step and eight steps. The first six
// steps use the one shared 17x28 multiplier in turn for the integral increment,
// derivative and the P, I (two halves) and D products, each product being used in the
// step after; the input is not ready again until the last step has written its result
// to the output register. If that register still holds an untaken result, the last
// step waits for it. The result beat carries P, I and D terms, the clamped pulse and
// its offset from 1500 us.
// Configuration is taken at any time on the cfg port and must be written while idle.
module pid_pwm_controller (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [15:0] error_value
  input  logic [1:0]   in_tuser,   // [1:0] operation
  // Result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [31:0] p_part, [63:32] i_part, [95:64] d_part,
                                   // [108:96] offset_drive, [120:109] pulse_width, rest 0
  // Configuration write channel
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  pidc_pkg::cfg_t      cfg_r;
  pidc_pkg::seq_ctrl_t ctrl;
  pidc_pkg::res_t      res;
  pidc_pkg::res_t      out_data_r;
  logic                out_valid_r;
  logic                out_free;
  logic                out_load;
  logic                in_fire;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p      <= 16'd256;
      cfg_r.gain_i      <= 16'd0;
      cfg_r.gain_d      <= 16'd0;
      cfg_r.tick_period <= 16'd3277;
      cfg_r.tick_rate   <= 10'd20;
      cfg_r.upper_limit <= 12'd2000;
      cfg_r.lower_limit <= 12'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pidc_pkg::REG_GAIN_P:      cfg_r.gain_p      <= cfg_data;
        pidc_pkg::REG_GAIN_I:      cfg_r.gain_i      <= cfg_data;
        pidc_pkg::REG_GAIN_D:      cfg_r.gain_d      <= cfg_data;
        pidc_pkg::REG_TICK_PERIOD: cfg_r.tick_period <= cfg_data;
        pidc_pkg::REG_TICK_RATE:   cfg_r.tick_rate   <= cfg_data[9:0];
        pidc_pkg::REG_UPPER_LIMIT: cfg_r.upper_limit <= cfg_data[11:0];
        pidc_pkg::REG_LOWER_LIMIT: cfg_r.lower_limit <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  pidc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .out_free (out_free),
    .in_ready (in_tready),
    .ctrl     (ctrl)
  );

  pidc_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .ctrl    (ctrl),
    .in_fire (in_fire),
    .in_op   (in_tuser),
    .in_err  (in_tdata),
    .res     (res)
  );

  // Hold the result beat until taken
  assign out_load = ctrl.commit && (ctrl.word.act == pidc_pkg::ACT_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

endmodule
